/* rtl/tbls_pkg.sv */
// Shared types and codes for the tiled Bresenham line stepper.
package tbls_pkg;

  localparam int unsigned DATA_BITS   = 40;
  localparam int unsigned MAP_BITS    = 10;
  localparam int unsigned HWORD_BITS  = 5;
  localparam int unsigned FIELD_BITS  = 8;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  // Input data word, last declared field in the lowest bits.
  typedef struct packed {
    logic [FIELD_BITS-1:0] color;
    logic [FIELD_BITS-1:0] end_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] start_x;
  } line_req_t;

  // Output data word, last declared field in the lowest bits.
  typedef struct packed {
    logic [FIELD_BITS-1:0] pixel_color;
    logic                  upper_byte;
    logic [HWORD_BITS-1:0] tile_halfword;
    logic [MAP_BITS-1:0]   map_entry_index;
    logic [FIELD_BITS-1:0] pixel_y;
    logic [FIELD_BITS-1:0] pixel_x;
  } pix_word_t;

  typedef struct packed {
    logic      last;
    pix_word_t word;
  } pixel_t;

endpackage

/* rtl/tbls_engine.sv */
// Line state registers and the combinational Bresenham step.
module tbls_engine import tbls_pkg::*; #(
  parameter int unsigned MAP_WIDTH_TILES = 32,
  parameter int unsigned COORD_BITS      = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  action_e   action_i,
  input  line_req_t req_i,
  output logic      res_valid_o,
  output pixel_t    res_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 3;

  logic [CW-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0]        tx_q, tx_d, ty_q, ty_d;
  logic                 xneg_q, xneg_d, yneg_q, yneg_d;
  logic [CW:0]          tdx_q, tdx_d, tdy_q, tdy_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 x_major_q, x_major_d;
  logic                 busy_q, busy_d;
  logic [7:0]           color_q, color_d;
  logic                 last;

  function automatic logic [CW-1:0] step_coord(logic [CW-1:0] v, logic negative);
    return negative ? v - CW'(1) : v + CW'(1);
  endfunction

  always_comb begin
    logic [CW-1:0]        sx, sy, ex, ey;
    logic [CW:0]          dx, dy;
    logic [CW-1:0]        adx, ady;
    logic signed [EW-1:0] sdx, sdy;
    logic                 minor;
    sx = CW'(req_i.start_x);
    sy = CW'(req_i.start_y);
    ex = CW'(req_i.end_x);
    ey = CW'(req_i.end_y);
    dx = {1'b0, ex} - {1'b0, sx};
    dy = {1'b0, ey} - {1'b0, sy};
    adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    sdx = EW'({1'b0, tdx_q});
    sdy = EW'({1'b0, tdy_q});
    minor = !err_q[EW-1];

    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    tx_d      = tx_q;
    ty_d      = ty_q;
    xneg_d    = xneg_q;
    yneg_d    = yneg_q;
    tdx_d     = tdx_q;
    tdy_d     = tdy_q;
    err_d     = err_q;
    x_major_d = x_major_q;
    busy_d    = busy_q;
    color_d   = color_q;
    last      = 1'b0;
    res_valid_o = 1'b0;

    if (action_i == ACT_START) begin
      res_valid_o = 1'b1;
      cur_x_d   = sx;
      cur_y_d   = sy;
      tx_d      = ex;
      ty_d      = ey;
      color_d   = req_i.color;
      xneg_d    = dx[CW];
      yneg_d    = dy[CW];
      tdx_d     = {adx, 1'b0};
      tdy_d     = {ady, 1'b0};
      // tie goes to y
      x_major_d = adx > ady;
      if (x_major_d) begin
        err_d = EW'({2'b00, ady, 1'b0}) - EW'({3'b000, adx});
        last  = sx == ex;
      end else begin
        err_d = EW'({2'b00, adx, 1'b0}) - EW'({3'b000, ady});
        last  = sy == ey;
      end
      busy_d = !last;
    end else if (busy_q) begin
      res_valid_o = 1'b1;
      if (x_major_q) begin
        if (minor) cur_y_d = step_coord(cur_y_q, yneg_q);
        cur_x_d = step_coord(cur_x_q, xneg_q);
        err_d   = err_q - (minor ? sdx : '0) + sdy;
        last    = cur_x_d == tx_q;
      end else begin
        if (minor) cur_x_d = step_coord(cur_x_q, xneg_q);
        cur_y_d = step_coord(cur_y_q, yneg_q);
        err_d   = err_q - (minor ? sdy : '0) + sdx;
        last    = cur_y_d == ty_q;
      end
      if (last) busy_d = 1'b0;
    end
  end

  always_comb begin
    logic [31:0] map_sum;
    map_sum = 32'(cur_x_d >> 3) + 32'(cur_y_d >> 3) * 32'(MAP_WIDTH_TILES);
    res_o.last                 = last;
    res_o.word.pixel_x         = 8'(cur_x_d);
    res_o.word.pixel_y         = 8'(cur_y_d);
    res_o.word.map_entry_index = map_sum[MAP_BITS-1:0];
    res_o.word.tile_halfword   = {cur_y_d[2:0], cur_x_d[2:1]};
    res_o.word.upper_byte      = cur_x_d[0];
    res_o.word.pixel_color     = color_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      tx_q      <= '0;
      ty_q      <= '0;
      xneg_q    <= 1'b0;
      yneg_q    <= 1'b0;
      tdx_q     <= '0;
      tdy_q     <= '0;
      err_q     <= '0;
      x_major_q <= 1'b0;
      busy_q    <= 1'b0;
      color_q   <= '0;
    end else if (accept_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      tx_q      <= tx_d;
      ty_q      <= ty_d;
      xneg_q    <= xneg_d;
      yneg_q    <= yneg_d;
      tdx_q     <= tdx_d;
      tdy_q     <= tdy_d;
      err_q     <= err_d;
      x_major_q <= x_major_d;
      busy_q    <= busy_d;
      color_q   <= color_d;
    end
  end

  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_valid_o && res_o.last |=> !busy_q)
    else $error("engine still busy after last pixel");

  a_idle_advance_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    action_i == ACT_ADVANCE && !busy_q |-> !res_valid_o)
    else $error("advance while idle produced a pixel");

  a_busy_not_at_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (x_major_q ? cur_x_q != tx_q : cur_y_q != ty_q))
    else $error("busy while major axis already at target");

endmodule

/* rtl/tiled_bresenham_line_stepper_core.sv */
// Top level: stream ports, line engine and registered output with skid stage.
// Draws lines into a tiled 8-bit background one pixel per accepted word: a
// start word (tuser = 0) loads both endpoints and a colour and yields the first
// pixel, each advance word (tuser = 1) yields the next pixel, and tlast marks
// the final pixel of the line; an advance with no line running yields nothing.
// One word is taken every cycle while tready is high; each pixel is worked out
// by the combinational step logic and is registered in the output register, or
// in the skid register while the output stalls. The skid register keeps input
// ready high for one more word while the output stalls, so tready only drops once both are full.
module tiled_bresenham_line_stepper_core import tbls_pkg::*; #(
  parameter int unsigned MAP_WIDTH_TILES = 32,
  parameter int unsigned COORD_BITS      = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], color[39:32]
  input  logic [DATA_BITS-1:0] s_axis_tdata,
  // action[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixel_x[7:0], pixel_y[15:8], map_entry_index[25:16], tile_halfword[30:26],
  // upper_byte[31], pixel_color[39:32]
  output logic [DATA_BITS-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic    accept, push, pop;
  logic    res_valid;
  pixel_t  res;
  action_e action;

  logic    m_valid_q, m_valid_d;
  pixel_t  m_data_q, m_data_d;
  logic    sk_valid_q, sk_valid_d;
  pixel_t  sk_data_q, sk_data_d;

  assign action = action_e'(s_axis_tuser);
  assign s_axis_tready = !sk_valid_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign push   = accept && res_valid;
  assign pop    = m_valid_q && m_axis_tready;

  tbls_engine #(
    .MAP_WIDTH_TILES (MAP_WIDTH_TILES),
    .COORD_BITS      (COORD_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action),
    .req_i       (line_req_t'(s_axis_tdata)),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    sk_valid_d = sk_valid_q;
    sk_data_d  = sk_data_q;
    if (!m_valid_q || pop) begin
      // refill from skid first; a push cannot coincide with a full skid
      m_valid_d  = sk_valid_q || push;
      m_data_d   = sk_valid_q ? sk_data_q : res;
      sk_valid_d = 1'b0;
    end else if (push) begin
      sk_valid_d = 1'b1;
      sk_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else begin
      m_valid_q  <= m_valid_d;
      sk_valid_q <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q  <= m_data_d;
    sk_data_q <= sk_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q.word;
  assign m_axis_tlast  = m_data_q.last;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> m_valid_q)
    else $error("skid holds a word while output register is empty");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !m_valid_q |=> m_valid_q && !sk_valid_q)
    else $error("pixel into empty output was lost or skidded");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !sk_valid_q && !push |=> !m_valid_q)
    else $error("output still valid after its only word was taken");

endmodule
